// ===== src/rsi_pkg.sv =====
// shared widths, types and register codes of the ray-sphere intersection core
package rsi_pkg;

  localparam int CoordW       = 32;
  localparam int DistW        = 31;
  localparam int NormW        = 16;
  localparam int UnitBits     = 30;
  localparam int UnitW        = 32;
  localparam int VecW         = 34;
  localparam int MagW         = 33;
  localparam int MantW        = 30;
  localparam int RootW        = 31;
  localparam int SqInW        = 2 * RootW;
  localparam int SqStages     = RootW;
  localparam int NumW         = 61;
  localparam int DivStages    = 31;
  localparam int NormFracBits = 14;
  localparam int NormShift    = UnitBits - NormFracBits;
  localparam int CfgIdxW      = 3;
  localparam int UvLat        = 5 + SqStages + 1 + DivStages + 1;
  localparam int CoreLat      = 1 + UvLat + 6 + SqStages + 4 + 1 + UvLat + 1;

  localparam logic [DistW-1:0] DistMax = '1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [UnitW-1:0]  unit_t;
  typedef logic signed [VecW-1:0]   vec_t;
  typedef logic signed [NormW-1:0]  norm_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3
  } cfg_reg_e;

endpackage

// ===== src/rsi_isqrt.sv =====
// pipelined floor square root, one root bit per stage
module rsi_isqrt #(
  parameter int SB_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [rsi_pkg::SqInW-1:0]  x_i,
  input  logic [SB_W-1:0]            sb_i,
  output logic                       out_valid_o,
  output logic [rsi_pkg::RootW-1:0]  root_o,
  output logic [SB_W-1:0]            sb_o
);
  import rsi_pkg::*;

  logic             vld_q  [SqStages];
  logic [RootW:0]   rem_q  [SqStages];
  logic [RootW-1:0] root_q [SqStages];
  logic [SqInW-1:0] x_q    [SqStages];
  logic [SB_W-1:0]  sb_q   [SqStages];

  for (genvar k = 0; k < SqStages; k++) begin : g_stage
    logic             vld_in;
    logic [RootW:0]   rem_in;
    logic [RootW-1:0] root_in;
    logic [SqInW-1:0] x_in;
    logic [SB_W-1:0]  sb_in;
    logic [RootW+2:0] rem_sh;
    logic [RootW+2:0] trial;
    logic [RootW+2:0] diff;
    logic             ge;

    if (k == 0) begin : g_head
      assign vld_in  = in_valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign sb_in   = sb_i;
    end else begin : g_body
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign sb_in   = sb_q[k-1];
    end

    // bring down the next bit pair and try the next root bit
    assign rem_sh = {rem_in, x_in[SqInW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[RootW:0] : rem_sh[RootW:0];
      root_q[k] <= {root_in[RootW-2:0], ge};
      x_q[k]    <= {x_in[SqInW-3:0], 2'b00};
      sb_q[k]   <= sb_in;
    end
  end

  assign out_valid_o = vld_q[SqStages-1];
  assign root_o      = root_q[SqStages-1];
  assign sb_o        = sb_q[SqStages-1];

endmodule

// ===== src/rsi_div3.sv =====
// pipelined restoring divider, three numerators over one divisor, one bit per stage
module rsi_div3 #(
  parameter int SB_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [rsi_pkg::RootW-1:0] n_i,
  input  logic [rsi_pkg::NumW-1:0]  num_i [3],
  input  logic [SB_W-1:0]           sb_i,
  output logic                      out_valid_o,
  output logic [rsi_pkg::RootW-1:0] quot_o [3],
  output logic [SB_W-1:0]           sb_o
);
  import rsi_pkg::*;

  logic                 vld_q [DivStages];
  logic [RootW-1:0]     n_q   [DivStages];
  logic [RootW-1:0]     rem_q [DivStages][3];
  logic [DivStages-1:0] lo_q  [DivStages][3];
  logic [RootW-1:0]     quo_q [DivStages][3];
  logic [SB_W-1:0]      sb_q  [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic                 vld_in;
    logic [RootW-1:0]     n_in;
    logic [SB_W-1:0]      sb_in;
    logic [RootW-1:0]     rem_in [3];
    logic [DivStages-1:0] lo_in  [3];
    logic [RootW-1:0]     quo_in [3];
    logic [RootW:0]       rem2   [3];
    logic [RootW:0]       diff   [3];
    logic [2:0]           ge;

    if (k == 0) begin : g_head
      assign vld_in = in_valid_i;
      assign n_in   = n_i;
      assign sb_in  = sb_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        // quotient fits in RootW bits, so the top part is already below n
        assign rem_in[l] = RootW'(num_i[l][NumW-1:DivStages]);
        assign lo_in[l]  = num_i[l][DivStages-1:0];
        assign quo_in[l] = '0;
      end
    end else begin : g_body
      assign vld_in = vld_q[k-1];
      assign n_in   = n_q[k-1];
      assign sb_in  = sb_q[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = rem_q[k-1][l];
        assign lo_in[l]  = lo_q[k-1][l];
        assign quo_in[l] = quo_q[k-1][l];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_step
      assign rem2[l] = {rem_in[l], lo_in[l][DivStages-1]};
      assign diff[l] = rem2[l] - {1'b0, n_in};
      assign ge[l]   = (rem2[l] >= {1'b0, n_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[k]  <= n_in;
      sb_q[k] <= sb_in;
      for (int l = 0; l < 3; l++) begin
        rem_q[k][l] <= ge[l] ? diff[l][RootW-1:0] : rem2[l][RootW-1:0];
        lo_q[k][l]  <= {lo_in[l][DivStages-2:0], 1'b0};
        quo_q[k][l] <= {quo_in[l][RootW-2:0], ge[l]};
      end
    end
  end

  assign out_valid_o = vld_q[DivStages-1];
  assign sb_o        = sb_q[DivStages-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quot_o[l] = quo_q[DivStages-1][l];
  end

endmodule

// ===== src/rsi_unit_vec.sv =====
// pipelined vector normalizer: block shift, sum of squares, root and three divides
module rsi_unit_vec #(
  parameter int SB_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  rsi_pkg::vec_t     q_i [3],
  input  logic [SB_W-1:0]   sb_i,
  output logic              out_valid_o,
  output logic              out_ok_o,
  output rsi_pkg::unit_t    u_o [3],
  output logic [SB_W-1:0]   sb_o
);
  import rsi_pkg::*;

  localparam int PosW  = $clog2(MagW);
  localparam logic [PosW-1:0] TopPos = PosW'(MantW - 1);
  localparam int SqSbW = SB_W + 3 * MantW + 4;
  localparam int DvSbW = SB_W + 4;

  // stage a: magnitudes and largest one
  vec_t            abs_a [3];
  logic [MagW-1:0] mag_a [3];
  logic [MagW-1:0] mx_a;
  logic [2:0]      neg_a;
  logic            va_q;
  logic [MagW-1:0] maga_q [3];
  logic [MagW-1:0] mxa_q;
  logic [2:0]      nega_q;
  logic [SB_W-1:0] sba_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_a[i] = q_i[i][VecW-1];
      abs_a[i] = neg_a[i] ? -q_i[i] : q_i[i];
      mag_a[i] = abs_a[i][MagW-1:0];
    end
    mx_a = mag_a[0];
    if (mag_a[1] > mx_a) mx_a = mag_a[1];
    if (mag_a[2] > mx_a) mx_a = mag_a[2];
  end

  always_ff @(posedge clk_i) begin
    maga_q <= mag_a;
    mxa_q  <= mx_a;
    nega_q <= neg_a;
    sba_q  <= sb_i;
  end

  // stage b: leading one of the largest magnitude
  logic [PosW-1:0] pos_b;
  logic            vb_q;
  logic [MagW-1:0] magb_q [3];
  logic [PosW-1:0] posb_q;
  logic [2:0]      negb_q;
  logic            okb_q;
  logic [SB_W-1:0] sbb_q;

  always_comb begin
    pos_b = '0;
    for (int b = 0; b < MagW; b++) begin
      if (mxa_q[b]) pos_b = PosW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    magb_q <= maga_q;
    posb_q <= pos_b;
    negb_q <= nega_q;
    okb_q  <= |mxa_q;
    sbb_q  <= sba_q;
  end

  // stage c: shift all three so the largest lands just below 2^30
  logic [MagW-1:0]  sh_c [3];
  logic             vc_q;
  logic [MantW-1:0] mc_q [3];
  logic [2:0]       negc_q;
  logic             okc_q;
  logic [SB_W-1:0]  sbc_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (posb_q > TopPos) begin
        sh_c[i] = magb_q[i] >> (posb_q - TopPos);
      end else begin
        sh_c[i] = magb_q[i] << (TopPos - posb_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mc_q[i] <= sh_c[i][MantW-1:0];
    end
    negc_q <= negb_q;
    okc_q  <= okb_q;
    sbc_q  <= sbb_q;
  end

  // stage d: squares
  logic               vd_q;
  logic [2*MantW-1:0] sqd_q [3];
  logic [MantW-1:0]   md_q [3];
  logic [2:0]         negd_q;
  logic               okd_q;
  logic [SB_W-1:0]    sbd_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sqd_q[i] <= (2*MantW)'(mc_q[i]) * (2*MantW)'(mc_q[i]);
    end
    md_q   <= mc_q;
    negd_q <= negc_q;
    okd_q  <= okc_q;
    sbd_q  <= sbc_q;
  end

  // stage e: sum of squares
  logic             ve_q;
  logic [SqInW-1:0] sse_q;
  logic [MantW-1:0] me_q [3];
  logic [2:0]       nege_q;
  logic             oke_q;
  logic [SB_W-1:0]  sbe_q;

  always_ff @(posedge clk_i) begin
    sse_q  <= SqInW'(sqd_q[0]) + SqInW'(sqd_q[1]) + SqInW'(sqd_q[2]);
    me_q   <= md_q;
    nege_q <= negd_q;
    oke_q  <= okd_q;
    sbe_q  <= sbd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  // root of the sum of squares
  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  logic [SqSbW-1:0] sq_sb;

  rsi_isqrt #(
    .SB_W (SqSbW)
  ) u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ve_q),
    .x_i         (sse_q),
    .sb_i        ({sbe_q, me_q[2], me_q[1], me_q[0], nege_q, oke_q}),
    .out_valid_o (sq_vld),
    .root_o      (sq_root),
    .sb_o        (sq_sb)
  );

  // stage p: rounded dividends
  logic             vp_q;
  logic [NumW-1:0]  nump_q [3];
  logic [RootW-1:0] np_q;
  logic [DvSbW-1:0] sbp_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      nump_q[i] <= NumW'({sq_sb[4 + MantW*i +: MantW], UnitBits'(0)})
                 + NumW'(sq_root >> 1);
    end
    np_q  <= sq_root;
    sbp_q <= {sq_sb[SqSbW-1 -: SB_W], sq_sb[3:0]};
  end

  logic             dv_vld;
  logic [RootW-1:0] dv_quot [3];
  logic [DvSbW-1:0] dv_sb;

  rsi_div3 #(
    .SB_W (DvSbW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vp_q),
    .n_i         (np_q),
    .num_i       (nump_q),
    .sb_i        (sbp_q),
    .out_valid_o (dv_vld),
    .quot_o      (dv_quot),
    .sb_o        (dv_sb)
  );

  // stage f: signs back on
  logic            vf_q;
  logic            okf_q;
  unit_t           uf_q [3];
  logic [SB_W-1:0] sbf_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      uf_q[i] <= dv_sb[1 + i] ? -$signed({1'b0, dv_quot[i]}) : $signed({1'b0, dv_quot[i]});
    end
    okf_q <= dv_sb[0];
    sbf_q <= dv_sb[DvSbW-1 -: SB_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      vp_q <= sq_vld;
      vf_q <= dv_vld;
    end
  end

  assign out_valid_o = vf_q;
  assign out_ok_o    = okf_q;
  assign u_o         = uf_q;
  assign sb_o        = sbf_q;

endmodule

// ===== src/ray_sphere_intersection_core.sv =====
// ray-sphere intersection core: top level pipeline
// throughput: one ray per cycle; busy_o stays low, the pipeline never stalls
// the depth is set by the two normalizers (root and divide, one bit per stage)
// and the root of the discriminant
// reset clears all valid bits and the sphere registers to zero
module ray_sphere_intersection_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  rsi_pkg::coord_t             origin_x_i,
  input  rsi_pkg::coord_t             origin_y_i,
  input  rsi_pkg::coord_t             origin_z_i,
  input  rsi_pkg::coord_t             dir_x_i,
  input  rsi_pkg::coord_t             dir_y_i,
  input  rsi_pkg::coord_t             dir_z_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rsi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rsi_pkg::CoordW-1:0]  cfg_data_i,
  output logic                        result_valid_o,
  output logic                        is_hit_o,
  output logic [rsi_pkg::DistW-1:0]   distance_o,
  output rsi_pkg::coord_t             point_x_o,
  output rsi_pkg::coord_t             point_y_o,
  output rsi_pkg::coord_t             point_z_o,
  output rsi_pkg::norm_t              normal_x_o,
  output rsi_pkg::norm_t              normal_y_o,
  output rsi_pkg::norm_t              normal_z_o
);
  import rsi_pkg::*;

  localparam int Sb1W   = 6 * CoordW;
  localparam int SideW  = 3 * CoordW + 3 * UnitW + 1;
  localparam int UvW    = 35;
  localparam int TW     = 36;
  localparam int SqSbW  = 3 * CoordW + 3 * UnitW + UvW + 1;
  localparam int Sb2W   = 1 + DistW + 3 * CoordW;
  localparam int SideN  = 5;
  localparam logic [65:0] Half66 = 66'd1 << (UnitBits - 1);
  localparam logic [63:0] Half64 = 64'd1 << (UnitBits - 1);
  localparam logic [32:0] HalfN  = 33'd1 << (NormShift - 1);

  function automatic coord_t sat33(logic signed [CoordW:0] x);
    coord_t r;
    if (x[CoordW] != x[CoordW-1]) begin
      r = x[CoordW] ? coord_t'({1'b1, {(CoordW-1){1'b0}}}) : coord_t'({1'b0, {(CoordW-1){1'b1}}});
    end else begin
      r = x[CoordW-1:0];
    end
    return r;
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // sphere registers
  coord_t           cen_q [3];
  logic [DistW-1:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '{default: '0};
      rad_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X: cen_q[0] <= cfg_data_i;
        REG_CENTER_Y: cen_q[1] <= cfg_data_i;
        REG_CENTER_Z: cen_q[2] <= cfg_data_i;
        REG_RADIUS:   rad_q    <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // stage t0: input transfer, v = center - origin
  coord_t org_in [3];
  coord_t dir_in [3];
  logic   v0_q;
  coord_t o0_q [3];
  coord_t v0c_q [3];
  vec_t   d0_q [3];

  assign org_in = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir_in = '{dir_x_i, dir_y_i, dir_z_i};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      o0_q[i]  <= org_in[i];
      d0_q[i]  <= VecW'(dir_in[i]);
      v0c_q[i] <= sat33($signed({cen_q[i][CoordW-1], cen_q[i]})
                      - $signed({org_in[i][CoordW-1], org_in[i]}));
    end
  end

  // direction to unit vector
  logic            u1_vld;
  logic            u1_ok;
  unit_t           u1_u [3];
  logic [Sb1W-1:0] u1_sb;

  rsi_unit_vec #(
    .SB_W (Sb1W)
  ) u_dir_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v0_q),
    .q_i         (d0_q),
    .sb_i        ({o0_q[2], o0_q[1], o0_q[0], v0c_q[2], v0c_q[1], v0c_q[0]}),
    .out_valid_o (u1_vld),
    .out_ok_o    (u1_ok),
    .u_o         (u1_u),
    .sb_o        (u1_sb)
  );

  // stages s1..s5 carry origin, direction and the nonzero flag alongside
  logic             vs_q   [SideN];
  logic [SideW-1:0] side_q [SideN];

  always_ff @(posedge clk_i) begin
    side_q[0] <= {u1_sb[CoordW*3 +: 3*CoordW], u1_u[2], u1_u[1], u1_u[0], u1_ok};
    for (int j = 1; j < SideN; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  // s1: products
  logic signed [63:0]     pu1_q [3];
  logic signed [63:0]     pv1_q [3];
  logic [2*DistW-1:0]     r2_1_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pu1_q[i] <= 64'(u1_u[i]) * 64'(coord_t'(u1_sb[CoordW*i +: CoordW]));
      pv1_q[i] <= 64'(coord_t'(u1_sb[CoordW*i +: CoordW]))
                * 64'(coord_t'(u1_sb[CoordW*i +: CoordW]));
    end
    r2_1_q <= (2*DistW)'(rad_q) * (2*DistW)'(rad_q);
  end

  // s2: dot product and squared length
  logic signed [65:0] uvs2_q;
  logic [63:0]        nv2_2_q;
  logic [2*DistW-1:0] r2_2_q;

  always_ff @(posedge clk_i) begin
    uvs2_q  <= 66'(pu1_q[0]) + 66'(pu1_q[1]) + 66'(pu1_q[2]);
    nv2_2_q <= 64'(pv1_q[0][62:0]) + 64'(pv1_q[1][62:0]) + 64'(pv1_q[2][62:0]);
    r2_2_q  <= r2_1_q;
  end

  // s3: rounded magnitude of the dot product
  logic [65:0]        mag3;
  logic [65:0]        rnd3;
  logic [32:0]        rmag3_q;
  logic               neg3_q;
  logic [63:0]        nv2_3_q;
  logic [2*DistW-1:0] r2_3_q;

  assign mag3 = uvs2_q[65] ? 66'(-uvs2_q) : 66'(uvs2_q);
  assign rnd3 = (mag3 + Half66) >> UnitBits;

  always_ff @(posedge clk_i) begin
    rmag3_q <= rnd3[32:0];
    neg3_q  <= uvs2_q[65];
    nv2_3_q <= nv2_2_q;
    r2_3_q  <= r2_2_q;
  end

  // s4: signed dot product and its square
  logic signed [UvW-1:0] uv4_q;
  logic [63:0]           uv2_4_q;
  logic [63:0]           nv2_4_q;
  logic [2*DistW-1:0]    r2_4_q;

  always_ff @(posedge clk_i) begin
    uv4_q   <= neg3_q ? -$signed({2'b00, rmag3_q}) : $signed({2'b00, rmag3_q});
    uv2_4_q <= 64'(rmag3_q[31:0]) * 64'(rmag3_q[31:0]);
    nv2_4_q <= nv2_3_q;
    r2_4_q  <= r2_3_q;
  end

  // s5: squared distance from center to the ray line
  logic signed [UvW-1:0] uv5_q;
  logic [63:0]           w2_5_q;
  logic [2*DistW-1:0]    r2_5_q;

  always_ff @(posedge clk_i) begin
    uv5_q  <= uv4_q;
    w2_5_q <= (nv2_4_q > uv2_4_q) ? (nv2_4_q - uv2_4_q) : 64'd0;
    r2_5_q <= r2_4_q;
  end

  // s6: discriminant
  logic             v6_q;
  logic [SqInW-1:0] a6_q;
  logic [SqSbW-1:0] sb6_q;
  logic [63:0]      a6_full;

  assign a6_full = 64'(r2_5_q) - w2_5_q;

  always_ff @(posedge clk_i) begin
    a6_q  <= a6_full[SqInW-1:0];
    sb6_q <= {side_q[4][SideW-1:1], uv5_q,
              side_q[4][0] && (64'(r2_5_q) > w2_5_q)};
  end

  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  logic [SqSbW-1:0] sq_sb;

  rsi_isqrt #(
    .SB_W (SqSbW)
  ) u_disc_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v6_q),
    .x_i         (a6_q),
    .sb_i        (sb6_q),
    .out_valid_o (sq_vld),
    .root_o      (sq_root),
    .sb_o        (sq_sb)
  );

  // s7: near root t and clamped distance
  logic signed [TW-1:0] t7;
  logic [DistW-1:0]     tu7_q;
  logic                 hit7_q;
  logic                 v7_q;
  coord_t               o7_q [3];
  unit_t                u7_q [3];

  assign t7 = $signed({sq_sb[UvW], sq_sb[UvW:1]}) - $signed({5'b00000, sq_root});

  always_ff @(posedge clk_i) begin
    hit7_q <= sq_sb[0] && !t7[TW-1] && (t7 != '0);
    tu7_q  <= (t7[TW-1:DistW] != '0) ? DistMax : t7[DistW-1:0];
    for (int i = 0; i < 3; i++) begin
      u7_q[i] <= sq_sb[UvW + 1 + UnitW*i +: UnitW];
      o7_q[i] <= sq_sb[UvW + 1 + 3*UnitW + CoordW*i +: CoordW];
    end
  end

  // s8: t * u
  logic signed [63:0] tp8_q [3];
  logic               hit8_q;
  logic [DistW-1:0]   tu8_q;
  coord_t             o8_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      tp8_q[i] <= 64'($signed({1'b0, tu7_q})) * 64'(u7_q[i]);
    end
    hit8_q <= hit7_q;
    tu8_q  <= tu7_q;
    o8_q   <= o7_q;
  end

  // s9: round the offsets
  logic [63:0]      mag9 [3];
  logic [63:0]      rnd9 [3];
  logic [33:0]      rmag9_q [3];
  logic [2:0]       neg9_q;
  logic             hit9_q;
  logic [DistW-1:0] tu9_q;
  coord_t           o9_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag9[i] = tp8_q[i][63] ? 64'(-tp8_q[i]) : 64'(tp8_q[i]);
      rnd9[i] = (mag9[i] + Half64) >> UnitBits;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rmag9_q[i] <= rnd9[i][33:0];
      neg9_q[i]  <= tp8_q[i][63];
    end
    hit9_q <= hit8_q;
    tu9_q  <= tu8_q;
    o9_q   <= o8_q;
  end

  // s10: hit point, saturated
  logic signed [TW-1:0] off10 [3];
  logic signed [TW-1:0] sum10 [3];
  coord_t               p10_q [3];
  logic                 hit10_q;
  logic [DistW-1:0]     tu10_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off10[i] = neg9_q[i] ? -$signed({2'b00, rmag9_q[i]}) : $signed({2'b00, rmag9_q[i]});
      sum10[i] = TW'(o9_q[i]) + off10[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (sum10[i] > TW'(coord_t'({1'b0, {(CoordW-1){1'b1}}}))) begin
        p10_q[i] <= coord_t'({1'b0, {(CoordW-1){1'b1}}});
      end else if (sum10[i] < TW'(coord_t'({1'b1, {(CoordW-1){1'b0}}}))) begin
        p10_q[i] <= coord_t'({1'b1, {(CoordW-1){1'b0}}});
      end else begin
        p10_q[i] <= sum10[i][CoordW-1:0];
      end
    end
    hit10_q <= hit9_q;
    tu10_q  <= tu9_q;
  end

  // s11: vector from hit point to center
  vec_t             q11_q [3];
  logic             v11_q;
  logic [Sb2W-1:0]  sb11_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q11_q[i] <= VecW'(cen_q[i]) - VecW'(p10_q[i]);
    end
    sb11_q <= {hit10_q, tu10_q, p10_q[2], p10_q[1], p10_q[0]};
  end

  logic            u2_vld;
  logic            u2_ok;
  unit_t           u2_u [3];
  logic [Sb2W-1:0] u2_sb;

  rsi_unit_vec #(
    .SB_W (Sb2W)
  ) u_nrm_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v11_q),
    .q_i         (q11_q),
    .sb_i        (sb11_q),
    .out_valid_o (u2_vld),
    .out_ok_o    (u2_ok),
    .u_o         (u2_u),
    .sb_o        (u2_sb)
  );

  // output stage: normal to Q1.14, miss masking
  logic [UnitW-1:0] nmag [3];
  logic [32:0]      nrnd [3];
  norm_t            nval [3];
  logic             hit_o;

  assign hit_o = u2_sb[Sb2W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = u2_u[i][UnitW-1] ? UnitW'(-u2_u[i]) : UnitW'(u2_u[i]);
      nrnd[i] = (33'(nmag[i]) + HalfN) >> NormShift;
      if (!u2_ok || !hit_o) begin
        nval[i] = '0;
      end else if (!u2_u[i][UnitW-1]) begin
        nval[i] = (nrnd[i] > 33'd32767) ? norm_t'(16'sd32767) : norm_t'(nrnd[i][NormW-1:0]);
      end else begin
        nval[i] = (nrnd[i] > 33'd32768) ? norm_t'(-17'sd32768)
                                          : -norm_t'(nrnd[i][NormW-1:0]);
      end
    end
  end

  logic             res_vld_q;
  logic             res_hit_q;
  logic [DistW-1:0] res_dist_q;
  coord_t           res_p_q [3];
  norm_t            res_n_q [3];

  always_ff @(posedge clk_i) begin
    res_hit_q  <= hit_o;
    res_dist_q <= hit_o ? u2_sb[3*CoordW +: DistW] : DistMax;
    for (int i = 0; i < 3; i++) begin
      res_p_q[i] <= hit_o ? coord_t'(u2_sb[CoordW*i +: CoordW]) : coord_t'(0);
    end
    res_n_q <= nval;
  end

  // valid line for s8..s10
  logic v8_q, v9_q, v10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      vs_q      <= '{default: 1'b0};
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      v11_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      v0_q  <= start_i;
      vs_q[0] <= u1_vld;
      for (int j = 1; j < SideN; j++) begin
        vs_q[j] <= vs_q[j-1];
      end
      v6_q      <= vs_q[4];
      v7_q      <= sq_vld;
      v11_q     <= v10_q;
      res_vld_q <= u2_vld;
    end
  end

  assign result_valid_o = res_vld_q;
  assign is_hit_o       = res_hit_q;
  assign distance_o     = res_dist_q;
  assign point_x_o      = res_p_q[0];
  assign point_y_o      = res_p_q[1];
  assign point_z_o      = res_p_q[2];
  assign normal_x_o     = res_n_q[0];
  assign normal_y_o     = res_n_q[1];
  assign normal_z_o     = res_n_q[2];

endmodule

// ===== src/rsi_checker.sv =====
// port-level checks for the ray-sphere intersection core, bound to the top level
module rsi_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        result_valid_o,
  input logic                        is_hit_o,
  input logic [rsi_pkg::DistW-1:0]   distance_o,
  input rsi_pkg::coord_t             point_x_o,
  input rsi_pkg::coord_t             point_y_o,
  input rsi_pkg::coord_t             point_z_o,
  input rsi_pkg::norm_t              normal_x_o,
  input rsi_pkg::norm_t              normal_y_o,
  input rsi_pkg::norm_t              normal_z_o
);
  import rsi_pkg::*;

  // every result goes back to a start transfer a fixed depth earlier
  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, CoreLat))
    else $error("result strobe without matching start");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !is_hit_o |->
      distance_o == DistMax && point_x_o == '0 && point_y_o == '0 && point_z_o == '0
      && normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("miss result carries nonzero fields");

  a_hit_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_hit_o |-> distance_o != '0)
    else $error("hit with zero distance");

endmodule

bind ray_sphere_intersection_core rsi_checker u_rsi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .is_hit_o       (is_hit_o),
  .distance_o     (distance_o),
  .point_x_o      (point_x_o),
  .point_y_o      (point_y_o),
  .point_z_o      (point_z_o),
  .normal_x_o     (normal_x_o),
  .normal_y_o     (normal_y_o),
  .normal_z_o     (normal_z_o)
);

// ===== test/ray_sphere_intersection_core_tb.sv =====
// self-checking testbench of the ray-sphere intersection core
`timescale 1ns / 100ps

module ray_sphere_intersection_core_tb;
  import rsi_pkg::*;

  localparam int  ClkPeriod   = 8;
  localparam int  CycleLimit  = 1000000;
  localparam int  DrainCycles = 400;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam longint I32Min = -64'sd2147483648;
  localparam longint I32Max = 64'sd2147483647;

  typedef longint trio_t [0:2];

  typedef struct {
    coord_t ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic             hit;
    logic [DistW-1:0] distance;
    coord_t           px, py, pz;
    norm_t            nx, ny, nz;
  } hit_info_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  coord_t origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  coord_t dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, result_valid_o, is_hit_o;
  logic [DistW-1:0] distance_o;
  coord_t point_x_o, point_y_o, point_z_o;
  norm_t normal_x_o, normal_y_o, normal_z_o;

  ray_sphere_intersection_core i_dut (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // sphere as seen by the predictor
  longint sph_c [0:2] = '{0, 0, 0};
  longint sph_r = 0;

  ray_t      ray_queue [$];
  hit_info_t hit_queue [$];
  int  mismatches = 0;
  int  gap_left = 0;
  bit  ray_taken = 1'b0;
  bit  no_gaps = 1'b0;
  longint cycles = 0;

  // ---------------- predictor ----------------
  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_shr(longint x, int sh);
    logic [63:0] m;
    m = x < 0 ? -x : x;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint x);
    return x < I32Min ? I32Min : (x > I32Max ? I32Max : x);
  endfunction

  function automatic bit make_unit(input trio_t q, output trio_t u);
    logic [63:0] m [0:2];
    logic [63:0] mx, ss, n, c;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = q[i] < 0 ? -q[i] : q[i];
      if (m[i] > mx) mx = m[i];
    end
    u = '{0, 0, 0};
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    n = root64(ss);
    for (int i = 0; i < 3; i++) begin
      c = ((m[i] << UnitBits) + (n >> 1)) / n;
      u[i] = q[i] < 0 ? -longint'(c) : longint'(c);
    end
    return 1'b1;
  endfunction

  function automatic hit_info_t trace_ray(ray_t r);
    hit_info_t h;
    trio_t o, d, u, p, q, nrm;
    longint v, uv, t, tu;
    logic [63:0] nv2, uv2, w2, r2, s;
    h = '{hit: 1'b0, distance: DistMax, default: '0};
    o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
    d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
    if (!make_unit(d, u)) return h;
    nv2 = 0;
    uv = 0;
    for (int i = 0; i < 3; i++) begin
      v = clamp32(sph_c[i] - o[i]);
      nv2 = nv2 + 64'(v * v);
      uv = uv + u[i] * v;
    end
    uv = round_shr(uv, UnitBits);
    uv2 = uv < 0 ? -uv : uv;
    uv2 = uv2 * uv2;
    w2 = nv2 > uv2 ? nv2 - uv2 : 0;
    r2 = sph_r * sph_r;
    if (r2 <= w2) return h;
    s = root64(r2 - w2);
    t = uv - longint'(s);
    if (t <= 0) return h;
    tu = t > I32Max ? I32Max : t;
    for (int i = 0; i < 3; i++) begin
      p[i] = clamp32(o[i] + round_shr(tu * u[i], UnitBits));
      q[i] = sph_c[i] - p[i];
    end
    if (make_unit(q, nrm)) begin
      for (int i = 0; i < 3; i++) begin
        nrm[i] = round_shr(nrm[i], NormShift);
        nrm[i] = nrm[i] < -32768 ? -32768 : (nrm[i] > 32767 ? 32767 : nrm[i]);
      end
    end
    h.hit = 1'b1;
    h.distance = tu[DistW-1:0];
    h.px = p[0][31:0];
    h.py = p[1][31:0];
    h.pz = p[2][31:0];
    h.nx = nrm[0][15:0];
    h.ny = nrm[1][15:0];
    h.nz = nrm[2][15:0];
    return h;
  endfunction

  // ---------------- driver ----------------
  function automatic int next_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk_i) begin
    ray_t r;
    if (rst_ni) begin
      if (start_i && !ray_taken) begin
        // hold the item until the transfer happens
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (ray_queue.size() > 0) begin
        r = ray_queue.pop_front();
        start_i <= 1'b1;
        origin_x_i <= r.ox;
        origin_y_i <= r.oy;
        origin_z_i <= r.oz;
        dir_x_i <= r.dx;
        dir_y_i <= r.dy;
        dir_z_i <= r.dz;
        gap_left <= next_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------- acceptance and monitor ----------------
  task automatic report(string what, longint want, longint got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin
    ray_t r;
    hit_info_t e;
    cycles <= cycles + 1;
    ray_taken <= start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      r = '{origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i};
      hit_queue.push_back(trace_ray(r));
    end
    if (rst_ni && result_valid_o) begin
      if (hit_queue.size() == 0) begin
        report("unexpected result, is_hit", -1, is_hit_o);
      end else begin
        e = hit_queue.pop_front();
        if (is_hit_o !== e.hit) report("is_hit", e.hit, is_hit_o);
        if (distance_o !== e.distance) report("distance", e.distance, distance_o);
        if (point_x_o !== e.px) report("point_x", e.px, point_x_o);
        if (point_y_o !== e.py) report("point_y", e.py, point_y_o);
        if (point_z_o !== e.pz) report("point_z", e.pz, point_z_o);
        if (normal_x_o !== e.nx) report("normal_x", e.nx, normal_x_o);
        if (normal_y_o !== e.ny) report("normal_y", e.ny, normal_y_o);
        if (normal_z_o !== e.nz) report("normal_z", e.nz, normal_z_o);
      end
    end
    if (cycles > CycleLimit) begin
      $display("ray_sphere_intersection_core: mismatch");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CENTER_X: sph_c[0] = longint'(signed'(data));
      REG_CENTER_Y: sph_c[1] = longint'(signed'(data));
      REG_CENTER_Z: sph_c[2] = longint'(signed'(data));
      REG_RADIUS:   sph_r = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_sphere(longint cx, longint cy, longint cz, longint rad);
    write_reg(REG_CENTER_X, cx[31:0]);
    write_reg(REG_CENTER_Y, cy[31:0]);
    write_reg(REG_CENTER_Z, cz[31:0]);
    write_reg(REG_RADIUS, rad[31:0]);
    // out-of-range index must leave the sphere alone
    write_reg(RegUnused, $urandom);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (ray_queue.size() != 0 || start_i || hit_queue.size() != 0);
  endtask

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
                                  longint dx, longint dy, longint dz);
    ray_t r;
    r.ox = ox[31:0]; r.oy = oy[31:0]; r.oz = oz[31:0];
    r.dx = dx[31:0]; r.dy = dy[31:0]; r.dz = dz[31:0];
    return r;
  endfunction

  // mostly rays aimed near the sphere, the rest raw noise
  function automatic ray_t random_ray(longint span);
    longint o [0:2];
    longint d [0:2];
    int shift, pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)
      return mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    shift = $urandom_range(0, 12);
    for (int i = 0; i < 3; i++) begin
      o[i] = clamp32(sph_c[i] + longint'($signed($urandom)) % span);
      d[i] = clamp32(sph_c[i] - o[i]) >>> shift;
      d[i] = d[i] + longint'($signed($urandom)) % ((sph_r >>> shift) + 2);
      if (pick < 30) d[i] = -d[i];
    end
    if (pick < 33) d = '{0, 0, 0};
    return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endfunction

  initial begin
    longint one, span;
    one = 64'sd65536;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sphere at reset: zero radius, everything misses
    for (int i = 0; i < 5; i++) ray_queue.push_back(random_ray(one * 8));
    wait_idle();

    // directed rays
    set_sphere(10 * one, 0, 0, 2 * one);
    ray_queue.push_back(mk_ray(0, 0, 0, one, 0, 0));
    ray_queue.push_back(mk_ray(0, 0, 0, 1, 0, 0));
    ray_queue.push_back(mk_ray(0, 0, 0, I32Max, 0, 0));
    ray_queue.push_back(mk_ray(0, 0, 0, -one, 0, 0));
    ray_queue.push_back(mk_ray(0, 0, 0, 0, one, 0));
    ray_queue.push_back(mk_ray(0, 0, 0, 0, 0, 0));
    ray_queue.push_back(mk_ray(10 * one, 0, 0, one, 0, 0));
    ray_queue.push_back(mk_ray(8 * one, 0, 0, one, 0, 0));
    ray_queue.push_back(mk_ray(0, 2 * one, 0, one, 0, 0));
    ray_queue.push_back(mk_ray(0, one, one, 5 * one, -one, -one));
    ray_queue.push_back(mk_ray(I32Min, I32Min, I32Min, I32Max, 0, 0));
    ray_queue.push_back(mk_ray(I32Max, I32Max, I32Max, I32Min, I32Min, I32Min));
    ray_queue.push_back(mk_ray(0, 0, 0, I32Min, I32Min, I32Min));
    ray_queue.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
    wait_idle();

    // far sphere: distance saturates and the point clamps
    set_sphere(I32Max, I32Max, I32Max, one);
    ray_queue.push_back(mk_ray(I32Min, I32Min, I32Min, one, one, one));
    ray_queue.push_back(mk_ray(I32Min, I32Min, I32Min, I32Max, I32Max, I32Max));
    ray_queue.push_back(mk_ray(0, 0, 0, 1, 1, 1));
    wait_idle();

    // largest radius from the far corner, and a hit right on the center
    set_sphere(I32Min, I32Min, I32Min, I32Max);
    ray_queue.push_back(mk_ray(I32Max, I32Max, I32Max, -1, -1, -1));
    ray_queue.push_back(mk_ray(0, 0, 0, -one, 0, 0));
    wait_idle();
    set_sphere(0, 0, 0, 1);
    ray_queue.push_back(mk_ray(-2, 0, 0, 1, 0, 0));
    ray_queue.push_back(mk_ray(-3, 0, 0, 1, 0, 0));
    wait_idle();

    // random phases over a range of sphere settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_sphere(longint'($signed($urandom)) >>> 8, longint'($signed($urandom)) >>> 8,
                      longint'($signed($urandom)) >>> 8, $urandom_range(one / 4, 64 * one));
        1: set_sphere(longint'($signed($urandom)), longint'($signed($urandom)),
                      longint'($signed($urandom)), {1'b0, $urandom} & I32Max);
        2: set_sphere(I32Min, I32Max, 0, $urandom_range(1, 4 * one));
        default: set_sphere(longint'($signed($urandom)) >>> 14, 0,
                            longint'($signed($urandom)) >>> 14, $urandom_range(1, one));
      endcase
      no_gaps = (ph % 3 == 2);
      span = sph_r * 4 + one;
      if (span > I32Max) span = I32Max;
      for (int i = 0; i < 250; i++) ray_queue.push_back(random_ray(span));
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("ray_sphere_intersection_core: match");
    end else begin
      $display("ray_sphere_intersection_core: mismatch");
    end
    $finish;
  end

endmodule
